// ----- hdl/infix_to_postfix_converter_core_defines.svh -----
// Assertion macros for the converter RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2P_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2P_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/i2p_pkg.sv -----
`default_nettype none
package i2p_pkg;

  localparam int I2P_STACK_DEPTH = 8;
  localparam int I2P_QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Character classes decided by the front end.
  typedef logic [2:0] cls_t;
  localparam cls_t CLS_DIGIT = 3'd0;
  localparam cls_t CLS_OPEN  = 3'd1;
  localparam cls_t CLS_CLOSE = 3'd2;
  localparam cls_t CLS_SPACE = 3'd3;
  localparam cls_t CLS_OPER  = 3'd4;

  // Precedence level: 2 for * and /, 1 for + and -, 0 for everything else.
  typedef logic [1:0] rank_t;

  typedef struct packed {
    logic [7:0] symbol;
    cls_t       cls;
    rank_t      rank;
    logic       is_last;
  } q_entry_t;

  function automatic rank_t rank_of(input logic [7:0] c);
    rank_t r;
    if (c == CH_STAR || c == CH_SLASH) begin
      r = 2'd2;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      r = 2'd1;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/i2p_in_if.sv -----
`default_nettype none
interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       is_last;

  modport source (output valid, output symbol, output is_last, input ready);
  modport sink   (input valid, input symbol, input is_last, output ready);
endinterface
`default_nettype wire

// ----- hdl/i2p_out_if.sv -----
`default_nettype none
interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       end_of_expression;
  logic       stack_error;

  modport source (output valid, output out_symbol, output end_of_expression,
                  output stack_error, input ready);
  modport sink   (input valid, input out_symbol, input end_of_expression,
                  input stack_error, output ready);
endinterface
`default_nettype wire

// ----- hdl/i2p_front.sv -----
`default_nettype none
module i2p_front (
  input  logic              clk,
  input  logic              rst_n,
  i2p_in_if.sink            in_chan,
  output logic              q_valid,
  output i2p_pkg::q_entry_t q_entry,
  input  logic              q_pop
);
  import i2p_pkg::*;

  localparam int PTR_W = (I2P_QUEUE_DEPTH > 1) ? $clog2(I2P_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(I2P_QUEUE_DEPTH + 1);

  q_entry_t         queue_r [I2P_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  logic             pop;
  q_entry_t         cls_entry;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(I2P_QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

  // Classify the incoming character once, so the back end only sequences.
  always_comb begin
    cls_entry.symbol  = in_chan.symbol;
    cls_entry.is_last = in_chan.is_last;
    cls_entry.rank    = rank_of(in_chan.symbol);
    if ((in_chan.symbol >= CH_ZERO && in_chan.symbol <= CH_NINE) ||
        in_chan.symbol == CH_DOT) begin
      cls_entry.cls = CLS_DIGIT;
    end else if (in_chan.symbol == CH_LPAREN) begin
      cls_entry.cls = CLS_OPEN;
    end else if (in_chan.symbol == CH_RPAREN) begin
      cls_entry.cls = CLS_CLOSE;
    end else if (in_chan.symbol == CH_SPACE) begin
      cls_entry.cls = CLS_SPACE;
    end else begin
      cls_entry.cls = CLS_OPER;
    end
  end

  assign in_chan.ready = (cnt_r != CNT_W'(I2P_QUEUE_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign pop           = q_pop && (cnt_r != CNT_W'(0));
  assign q_valid       = (cnt_r != CNT_W'(0));
  assign q_entry       = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cls_entry;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/i2p_back.sv -----
`default_nettype none
`include "infix_to_postfix_converter_core_defines.svh"
module i2p_back #(
  parameter int STACK_DEPTH = i2p_pkg::I2P_STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  i2p_pkg::q_entry_t q_entry,
  output logic              q_pop,
  i2p_out_if.source         out_chan
);
  import i2p_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_HEAD      = 4'd1;
  localparam logic [3:0] S_CLOSE     = 4'd2;
  localparam logic [3:0] S_CLOSE_SP  = 4'd3;
  localparam logic [3:0] S_OPER      = 4'd4;
  localparam logic [3:0] S_OPER_SP   = 4'd5;
  localparam logic [3:0] S_FLUSH_SP  = 4'd6;
  localparam logic [3:0] S_FLUSH     = 4'd7;
  localparam logic [3:0] S_FLUSH_PSP = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             err_r, err_nxt;
  q_entry_t         cur_r, cur_nxt;
  logic [7:0]       stack_r [STACK_DEPTH];

  logic             out_vld_r, out_vld_nxt;
  logic [7:0]       out_sym_r;
  logic             out_eoe_r;
  logic             out_err_r;

  logic             slot_free;
  logic             emit;
  logic [7:0]       emit_sym;
  logic             emit_eoe;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] top_pos;
  logic [7:0]       top_sym;
  logic [3:0]       tail_state;

  assign slot_free  = !out_vld_r || out_chan.ready;
  assign full       = (cnt_r == CNT_W'(STACK_DEPTH));
  assign empty      = (cnt_r == CNT_W'(0));
  assign top_pos    = cnt_r - CNT_W'(1);
  assign top_sym    = stack_r[top_pos[IDX_W-1:0]];
  assign tail_state = cur_r.is_last ? S_FLUSH_SP : S_IDLE;

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    cur_nxt   = cur_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_sym  = CH_SPACE;
    emit_eoe  = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_entry;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        unique case (cur_r.cls)
          CLS_DIGIT: begin
            if (slot_free) begin
              emit      = 1'b1;
              emit_sym  = cur_r.symbol;
              state_nxt = tail_state;
            end
          end
          CLS_OPEN: begin
            push      = 1'b1;
            state_nxt = tail_state;
          end
          CLS_SPACE: begin
            state_nxt = tail_state;
          end
          CLS_CLOSE: begin
            if (slot_free) begin
              emit      = 1'b1;
              state_nxt = S_CLOSE;
            end
          end
          default: begin
            if (slot_free) begin
              emit      = 1'b1;
              state_nxt = S_OPER;
            end
          end
        endcase
      end
      S_CLOSE: begin
        if (!empty && top_sym != CH_LPAREN) begin
          if (slot_free) begin
            emit     = 1'b1;
            emit_sym = top_sym;
            pop      = 1'b1;
            if (top_sym == CH_STAR || top_sym == CH_SLASH) begin
              state_nxt = S_CLOSE_SP;
            end
          end
        end else begin
          if (!empty) begin
            pop = 1'b1;
          end else begin
            err_nxt = 1'b1;
          end
          state_nxt = tail_state;
        end
      end
      S_OPER: begin
        if (!empty && cur_r.rank <= rank_of(top_sym)) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_sym  = top_sym;
            pop       = 1'b1;
            state_nxt = S_OPER_SP;
          end
        end else begin
          push      = 1'b1;
          state_nxt = tail_state;
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          emit = 1'b1;
          if (!empty) begin
            emit_sym  = top_sym;
            pop       = 1'b1;
            state_nxt = S_FLUSH_PSP;
          end else begin
            emit_eoe  = 1'b1;
            err_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      S_CLOSE_SP, S_OPER_SP, S_FLUSH_SP, S_FLUSH_PSP: begin
        if (slot_free) begin
          emit = 1'b1;
          case (state_r)
            S_CLOSE_SP: state_nxt = S_CLOSE;
            S_OPER_SP:  state_nxt = S_OPER;
            default:    state_nxt = S_FLUSH;
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    cnt_nxt = cnt_r;
    if (push) begin
      if (full) begin
        err_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end else if (pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end

    out_vld_nxt = out_vld_r;
    if (slot_free) begin
      out_vld_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      err_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      err_r     <= err_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (push && !full) begin
      stack_r[cnt_r[IDX_W-1:0]] <= cur_r.symbol;
    end
    if (emit) begin
      out_sym_r <= emit_sym;
      out_eoe_r <= emit_eoe;
      out_err_r <= err_r;
    end
  end

  assign out_chan.valid             = out_vld_r;
  assign out_chan.out_symbol        = out_sym_r;
  assign out_chan.end_of_expression = out_eoe_r;
  assign out_chan.stack_error       = out_err_r;

  `I2P_ASSERT_IMP(a_eoe_empty, emit && emit_eoe, cnt_r == CNT_W'(0), "end of expression with entries left")
  `I2P_ASSERT_NXT(a_eoe_clears, emit && emit_eoe, !err_r, "error flag not cleared after flush")
  `I2P_ASSERT_IMP(a_pop_nonempty, pop, cnt_r != CNT_W'(0), "pop from an empty stack")
  `I2P_ASSERT_IMP(a_cnt_bound, out_vld_r || !out_vld_r, cnt_r <= CNT_W'(STACK_DEPTH), "stack count beyond depth")

endmodule
`default_nettype wire

// ----- hdl/infix_to_postfix_converter_core.sv -----
// Infix to postfix converter: accepts one ASCII character of an infix expression per input
// transaction and returns the postfix text one character per output transaction, with
// spaces between tokens, using an operator stack of STACK_DEPTH entries (2 or more). The
// back-end sequencer sets the timing. It takes a character from the internal queue in its
// idle state and decodes it in its head state. The decoding step also produces the first
// output character, pushes a '(' or drops a space. Every further output character takes
// one more step. So does each stack step that produces no output: the push that ends an
// operator, and the last step of a ')', which pops the matching '(' or finds that none is
// open. A character marked last is followed by a flush of two output characters plus two
// for every stack entry. Stalls on the output hold the sequencer; the input side keeps
// accepting until its two-entry queue is full. The stack needs no clearing after reset.
`default_nettype none
module infix_to_postfix_converter_core #(
  parameter int STACK_DEPTH = i2p_pkg::I2P_STACK_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  i2p_in_if.sink    in_chan,
  i2p_out_if.source out_chan
);
  import i2p_pkg::*;

  // Classified characters travel from the front end to the back end through a short queue,
  // so that a slow flush on the output side does not stop input transactions at once.
  logic     q_valid;
  q_entry_t q_entry;
  logic     q_pop;

  // The front end decodes each character into its class and precedence and queues it.
  i2p_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  // The back end owns the operator stack and the sticky error flag. It walks each queued
  // character through its pops and pushes and registers every output character, so a result
  // waiting to be taken never blocks the queue from filling.
  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire
